// File: rtl/core/tcw_pkg.sv
// shared types and constants for the text console writer
package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // cell address width at the largest geometry (128 x 32 cells)
  localparam int CELL_AW_MAX = 12;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // reset values of the colour registers
  localparam logic [3:0] TEXT_COLOUR_RST       = 4'd7;
  localparam logic [3:0] BACKGROUND_COLOUR_RST = 4'd0;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_TEXT_COLOUR       = 1'b0,
    CFG_BACKGROUND_COLOUR = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FILL_NONE = 2'd0,
    FILL_ROW  = 2'd1,
    FILL_ALL  = 2'd2
  } fill_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic        scrolled;
  } result_t;

  // one classified job handed from the front to the back
  typedef struct packed {
    logic                   wr_en;
    logic                   rd_en;
    logic [CELL_AW_MAX-1:0] addr;
    logic [15:0]            wr_data;
    fill_t                  fill;
    logic [CELL_AW_MAX-1:0] fill_base;
    logic [15:0]            fill_data;
    result_t                res;
  } job_t;

endpackage

// File: rtl/core/tcw_front.sv
// command front end: cursor, scroll base row, colour registers and job classification
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cmd_t     cmd,
  output logic     busy,
  input  logic     cfg_valid,
  input  cfg_reg_t cfg_index,
  input  logic [3:0] cfg_data,
  input  logic     q_full,
  input  logic     init_busy,
  output logic     push,
  output job_t     job
);

  localparam logic [7:0] COL_LIM = 8'(COLUMNS);
  localparam logic [5:0] ROW_LIM = 6'(ROWS);

  logic [6:0] cur_col, cur_col_next;
  logic [4:0] cur_row, cur_row_next;
  logic [4:0] top, top_next;
  logic [3:0] text_colour;
  logic [3:0] background_colour;

  logic       accept;
  logic [7:0] attr;
  logic       in_range;
  logic [4:0] sel_row;
  logic [6:0] sel_col;
  logic [5:0] phys_sum;
  logic [4:0] phys_row;
  logic [CELL_AW_MAX-1:0] cell_addr;
  logic [7:0] col_inc;
  logic [5:0] row_inc;
  logic [5:0] top_inc;
  logic [4:0] top_wrap;
  logic [11:0] offset_full;

  assign busy   = q_full | init_busy;
  assign accept = start & ~busy;
  assign push   = accept;

  // colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_colour       <= TEXT_COLOUR_RST;
      background_colour <= BACKGROUND_COLOUR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEXT_COLOUR:       text_colour       <= cfg_data;
        CFG_BACKGROUND_COLOUR: background_colour <= cfg_data;
        default: ;
      endcase
    end
  end

  assign attr     = {background_colour, text_colour};
  assign in_range = ({1'b0, cmd.col} < COL_LIM) && ({1'b0, cmd.row} < ROW_LIM);

  // logical row to physical row, the store is a ring of rows starting at top
  assign sel_row  = (cmd.op == OP_READ) ? cmd.row : cur_row;
  assign sel_col  = (cmd.op == OP_READ) ? cmd.col : cur_col;
  assign phys_sum = {1'b0, sel_row} + {1'b0, top};
  assign phys_row = (phys_sum >= ROW_LIM) ? 5'(phys_sum - ROW_LIM) : phys_sum[4:0];
  assign cell_addr = CELL_AW_MAX'(phys_row) * CELL_AW_MAX'(COLUMNS)
                   + CELL_AW_MAX'(sel_col);

  assign col_inc  = {1'b0, cur_col} + 8'd1;
  assign row_inc  = {1'b0, cur_row} + 6'd1;
  assign top_inc  = {1'b0, top} + 6'd1;
  assign top_wrap = (top_inc == ROW_LIM) ? 5'd0 : top_inc[4:0];

  // classify the command and work out the new cursor
  always_comb begin
    logic wrap;
    wrap         = 1'b0;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    top_next     = top;
    job          = '0;
    job.fill     = FILL_NONE;
    job.fill_data = {attr, SPACE_CODE};
    unique case (cmd.op)
      OP_PUT: begin
        if (cmd.char_code == NEWLINE_CODE) begin
          wrap = 1'b1;
        end else begin
          job.wr_en   = 1'b1;
          job.addr    = cell_addr;
          job.wr_data = {attr, cmd.char_code};
          if (col_inc == COL_LIM) begin
            wrap = 1'b1;
          end else begin
            cur_col_next = col_inc[6:0];
          end
        end
        if (wrap) begin
          cur_col_next = 7'd0;
          if (row_inc == ROW_LIM) begin
            // old top row becomes the blank bottom line
            job.res.scrolled = 1'b1;
            job.fill         = FILL_ROW;
            job.fill_base    = CELL_AW_MAX'(top) * CELL_AW_MAX'(COLUMNS);
            top_next         = top_wrap;
          end else begin
            cur_row_next = row_inc[4:0];
          end
        end
      end
      OP_CLEAR: begin
        job.fill     = FILL_ALL;
        cur_col_next = 7'd0;
        cur_row_next = 5'd0;
        top_next     = 5'd0;
      end
      OP_SET: begin
        if (in_range) begin
          cur_col_next = cmd.col;
          cur_row_next = cmd.row;
        end
      end
      OP_READ: begin
        if (in_range) begin
          job.rd_en = 1'b1;
          job.addr  = cell_addr;
        end
      end
      default: ;
    endcase
    job.res.cursor_col    = cur_col_next;
    job.res.cursor_row    = cur_row_next;
    job.res.cursor_offset = offset_full[10:0];
  end

  assign offset_full = 12'(cur_row_next) * 12'(COLUMNS) + 12'(cur_col_next);

  // cursor and ring base
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= 7'd0;
      cur_row <= 5'd0;
      top     <= 5'd0;
    end else if (accept) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      top     <= top_next;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < COL_LIM) && ({1'b0, cur_row} < ROW_LIM))
    else $error("cursor left the screen");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, top} < ROW_LIM)
    else $error("ring base row out of range");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.op == OP_CLEAR) |=> (cur_col == 7'd0) && (cur_row == 5'd0) && (top == 5'd0))
    else $error("clear screen did not home cursor and ring base");

endmodule

// File: rtl/core/tcw_queue.sv
// two-entry job queue between front and back
module tcw_queue import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level, level holds when push and pop meet or both idle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/tcw_back.sv
// back end: cell store, clearing pass, row and screen fills, result register
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    empty,
  input  job_t    job,
  output logic    pop,
  output logic    init_busy,
  output logic    done,
  output result_t result
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_RUN,
    ST_FILL
  } state_t;

  state_t      state;
  logic [AW-1:0] cnt;
  logic [AW-1:0] left;
  logic [15:0] fill_data;
  result_t     hold_res;
  result_t     out_res;
  logic        out_valid;
  logic        out_rd;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic        mem_re;

  assign pop       = (state == ST_RUN) && !empty;
  assign init_busy = (state == ST_INIT);
  assign mem_re    = pop && job.rd_en;

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = 16'd0;
    unique case (state)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_RUN: begin
        mem_we    = pop && job.wr_en;
        mem_waddr = job.addr[AW-1:0];
        mem_wdata = job.wr_data;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_data;
      end
      default: ;
    endcase
  end

  // cell store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[job.addr[AW-1:0]];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          if (cnt == AW'(CELLS - 1)) begin
            state <= ST_RUN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_RUN: begin
          if (pop) begin
            if (job.fill == FILL_NONE) begin
              out_valid <= 1'b1;
              out_res   <= job.res;
              out_rd    <= job.rd_en;
            end else begin
              state     <= ST_FILL;
              cnt       <= job.fill_base[AW-1:0];
              left      <= (job.fill == FILL_ALL) ? AW'(CELLS - 1) : AW'(COLUMNS - 1);
              fill_data <= job.fill_data;
              hold_res  <= job.res;
            end
          end
        end
        ST_FILL: begin
          if (left == '0) begin
            state     <= ST_RUN;
            out_valid <= 1'b1;
            out_res   <= hold_res;
            out_rd    <= 1'b0;
          end else begin
            cnt  <= cnt + 1'b1;
            left <= left - 1'b1;
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  // result beat, read data merged in for cell reads
  always_comb begin
    result = out_res;
    if (out_rd) begin
      result.cell_char = rdata[7:0];
      result.cell_attr = rdata[15:8];
    end
  end

  assign done = out_valid;

  a_no_beat_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> !out_valid)
    else $error("result beat during clearing pass");

  a_fill_ends_in_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) && (left == '0) |=> out_valid && (state == ST_RUN))
    else $error("fill finished without a result beat");

  a_read_beat: assert property (@(posedge clk) disable iff (rst)
    pop && job.rd_en && (job.fill == FILL_NONE) |=> out_valid && out_rd)
    else $error("cell read did not produce a read beat");

endmodule

// File: rtl/core/text_console_writer.sv
// text console writer: for put, set and read, a job runs from start through the queue slot
// and the result register to done. put, set and read sustain one item per cycle while busy stays low;
// a scroll fills one row through the single write port and a clear fills the whole screen.
// the screen is a ring of rows, so a scroll only blanks one row.
// after reset the cell store is cleared one cell per cycle: busy stays high until all
// ROWS*COLUMNS cells (2000 at 80x25) are cleared. results cannot be stalled by the receiver.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cmd_t       cmd,
  output logic       busy,
  output logic       done,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_reg_t   cfg_index,
  input  logic [3:0] cfg_data
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  logic init_busy;
  job_t push_job;
  job_t pop_job;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .init_busy(init_busy),
    .push     (push),
    .job      (push_job)
  );

  tcw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .job      (pop_job),
    .pop      (pop),
    .init_busy(init_busy),
    .done     (done),
    .result   (result)
  );

endmodule

// File: tb/text_console_writer_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the text console writer: shadow screen, directed and random commands
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS           = COLUMNS_DEF;
  localparam int ROWS           = ROWS_DEF;
  localparam int CELLS          = COLS * ROWS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2 * COLS + 20;
  localparam int PHASE_ITEMS    = 95;
  localparam int PHASES         = 6;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  cmd_t       cmd       = '0;
  logic       busy;
  logic       done;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_reg_t   cfg_index = CFG_TEXT_COLOUR;
  logic [3:0] cfg_data  = '0;

  // shadow copy of the console state
  logic [15:0] shadow_cells [CELLS];
  int          shadow_col = 0;
  int          shadow_row = 0;
  logic [3:0]  fg_colour  = TEXT_COLOUR_RST;
  logic [3:0]  bg_colour  = BACKGROUND_COLOUR_RST;

  cmd_t    cmd_backlog[$];
  result_t pending_results[$];
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  int      burst_left     = 1;
  int      gap_left       = 0;

  text_console_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // fill one row with spaces in the current attribute
  function automatic void blank_row(int r);
    for (int i = 0; i < COLS; i++) begin
      shadow_cells[r * COLS + i] = {bg_colour, fg_colour, SPACE_CODE};
    end
  endfunction

  // apply one command to the shadow console and return the result it should give
  function automatic result_t console_step(cmd_t c);
    result_t r;
    logic [15:0] cell_word;
    r = '0;
    case (c.op)
      OP_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          shadow_col = 0;
          shadow_row++;
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = {bg_colour, fg_colour, c.char_code};
          shadow_col++;
          if (shadow_col >= COLS) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        // ran off the bottom: scroll up one line
        if (shadow_row >= ROWS) begin
          for (int i = 0; i + COLS < CELLS; i++) begin
            shadow_cells[i] = shadow_cells[i + COLS];
          end
          blank_row(ROWS - 1);
          r.scrolled = 1'b1;
          shadow_col = 0;
          shadow_row = ROWS - 1;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < ROWS; i++) begin
          blank_row(i);
        end
        shadow_col = 0;
        shadow_row = 0;
      end
      OP_SET: begin
        if (c.col < COLS && c.row < ROWS) begin
          shadow_col = int'(c.col);
          shadow_row = int'(c.row);
        end
      end
      default: begin
        if (c.col < COLS && c.row < ROWS) begin
          cell_word   = shadow_cells[c.row * COLS + c.col];
          r.cell_char = cell_word[7:0];
          r.cell_attr = cell_word[15:8];
        end
      end
    endcase
    r.cursor_col    = shadow_col[6:0];
    r.cursor_row    = shadow_row[4:0];
    r.cursor_offset = 11'(shadow_row * COLS + shadow_col);
    return r;
  endfunction

  // command driver: bursts of beats with random gaps
  always @(posedge clk) begin : sender
    logic next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        pending_results.push_back(console_step(cmd));
        next_start = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          cmd <= cmd_backlog.pop_front();
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // result monitor: compare each beat with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: %p", result);
        end
      end else begin
        want = pending_results.pop_front();
        if (result.cell_char !== want.cell_char || result.cell_attr !== want.cell_attr ||
            result.cursor_col !== want.cursor_col || result.cursor_row !== want.cursor_row ||
            result.cursor_offset !== want.cursor_offset || result.scrolled !== want.scrolled)
        begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected %p, got %p", want, result);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_cmd(op_t op, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
    cmd_t item;
    item.op        = op;
    item.char_code = ch;
    item.col       = c;
    item.row       = r;
    cmd_backlog.push_back(item);
  endtask

  // one put with mostly printable text, some newlines and raw bytes
  task automatic queue_text_char();
    int pick;
    logic [7:0] ch;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      ch = NEWLINE_CODE;
    end else if (pick == 2) begin
      ch = 8'($urandom_range(0, 255));
    end else begin
      ch = 8'($urandom_range(8'h20, 8'h7e));
    end
    queue_cmd(OP_PUT, ch, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
  endtask

  // random traffic built from short command sequences
  task automatic queue_random(int count);
    int queued;
    int kind;
    int len;
    logic [21:0] raw;
    queued = 0;
    while (queued < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // run of text
        len = $urandom_range(1, 40);
        repeat (len) queue_text_char();
        queued += len;
      end else if (kind < 65) begin
        // jump near the bottom and type, to force scrolls
        queue_cmd(OP_SET, 8'($urandom_range(0, 255)), 7'($urandom_range(0, COLS - 1)),
                  5'($urandom_range(ROWS - 5, ROWS - 1)));
        len = $urandom_range(1, 100);
        repeat (len) queue_text_char();
        queued += len + 1;
      end else if (kind < 85) begin
        // cell reads, mostly in range
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 4) != 0) begin
            queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, COLS - 1)),
                      5'($urandom_range(0, ROWS - 1)));
          end else begin
            queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                      5'($urandom_range(0, 31)));
          end
        end
        queued += len;
      end else if (kind < 95) begin
        // cursor move, in or out of range
        queue_cmd(OP_SET, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                  5'($urandom_range(0, 31)));
        queued++;
      end else if (kind < 97) begin
        queue_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                  5'($urandom_range(0, 31)));
        queued++;
      end else begin
        // raw noise
        len = $urandom_range(1, 3);
        repeat (len) begin
          raw = 22'($urandom);
          cmd_backlog.push_back(cmd_t'(raw));
        end
        queued += len;
      end
    end
  endtask

  // block until nothing is queued, in flight or being filled
  task automatic wait_quiet();
    int calm;
    calm = 0;
    while (calm < 4) begin
      @(negedge clk);
      if (cmd_backlog.size() == 0 && !start && pending_results.size() == 0 && !busy) begin
        calm++;
      end else begin
        calm = 0;
      end
    end
  endtask

  // one register write beat, shadowed once accepted
  task automatic write_colour(cfg_reg_t idx, logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TEXT_COLOUR) begin
      fg_colour = val;
    end else begin
      bg_colour = val;
    end
  endtask

  // stimulus sequencing
  initial begin
    logic [3:0] fg;
    logic [3:0] bg;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset contents, extremes, wrap, scroll, ignored moves, clear
    queue_cmd(OP_READ, 8'h00, 7'd0, 5'd0);
    queue_cmd(OP_READ, 8'hff, 7'd127, 5'd31);
    queue_cmd(OP_PUT, 8'h41, 7'd0, 5'd0);
    queue_cmd(OP_PUT, 8'hff, 7'd127, 5'd31);
    queue_cmd(OP_PUT, 8'h00, 7'd0, 5'd0);
    queue_cmd(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    queue_cmd(OP_READ, 8'h00, 7'd1, 5'd0);
    queue_cmd(OP_SET, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
    queue_cmd(OP_PUT, 8'h5a, 7'd0, 5'd0);
    queue_cmd(OP_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 2));
    queue_cmd(OP_READ, 8'h00, 7'd0, 5'(ROWS - 1));
    queue_cmd(OP_SET, 8'h00, 7'(COLS), 5'd0);
    queue_cmd(OP_SET, 8'h00, 7'd0, 5'(ROWS));
    queue_cmd(OP_SET, 8'hff, 7'd127, 5'd31);
    queue_cmd(OP_SET, 8'h00, 7'd0, 5'(ROWS - 1));
    queue_cmd(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    queue_cmd(OP_SET, 8'h00, 7'(COLS - 2), 5'd3);
    queue_cmd(OP_PUT, 8'h78, 7'd0, 5'd0);
    queue_cmd(OP_PUT, 8'h79, 7'd0, 5'd0);
    queue_cmd(OP_READ, 8'h00, 7'(COLS - 2), 5'd3);
    queue_cmd(OP_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
    queue_cmd(OP_CLEAR, 8'h00, 7'd0, 5'd0);
    queue_cmd(OP_READ, 8'h00, 7'd40, 5'd12);
    queue_cmd(OP_PUT, 8'h7e, 7'd0, 5'd0);

    // random phases, each under its own colour setting
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      case (p)
        0: begin
          fg = 4'd15;
          bg = 4'd15;
        end
        1: begin
          fg = 4'd0;
          bg = 4'd0;
        end
        2: begin
          fg = 4'd15;
          bg = 4'd0;
        end
        3: begin
          fg = 4'd0;
          bg = 4'd15;
        end
        default: begin
          fg = 4'($urandom_range(0, 15));
          bg = 4'($urandom_range(0, 15));
        end
      endcase
      write_colour(CFG_TEXT_COLOUR, fg);
      write_colour(CFG_BACKGROUND_COLOUR, bg);
      @(negedge clk);
      queue_random(PHASE_ITEMS);
    end

    // drain and settle
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
